[rtl/core/mtsg_pkg.sv]
// Shared types, constants and helpers of the march test sequence generator.
package mtsg_pkg;

    localparam int ADDR_W      = 30;
    localparam int ELEM_W      = 3;
    localparam int OP_W        = 2;
    localparam int OPS_W       = 3;
    localparam int PROG_W      = 64;
    localparam int LOG2_W      = 5;
    localparam int COUNT_W     = 4;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = ADDR_W + 1 + ELEM_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int DEF_MAX_ELEMENTS = 8;
    localparam int DEF_MAX_OPS      = 4;
    localparam int DEF_ADDR_BITS    = 30;

    localparam logic [LOG2_W-1:0]  RST_MEM_SIZE_LOG2 = LOG2_W'(20);
    localparam logic [COUNT_W-1:0] RST_ELEMENT_COUNT = COUNT_W'(1);
    localparam logic [PROG_W-1:0]  RST_MARCH_PROGRAM = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEM_SIZE_LOG2 = 2'd0,
        CFG_ELEMENT_COUNT = 2'd1,
        CFG_MARCH_PROGRAM = 2'd2
    } cfg_index_t;

    // Configuration after range clamping
    typedef struct packed {
        logic [LOG2_W-1:0]  size_log2;
        logic [COUNT_W-1:0] elem_count;
        logic [PROG_W-1:0]  prog;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic              is_write;
        logic [ELEM_W-1:0] element_index;
        logic              last;
    } result_t;

    // Descriptor byte of one march element
    function automatic logic [BYTE_W-1:0] elem_byte(input logic [PROG_W-1:0] prog,
                                                    input logic [ELEM_W-1:0] elem);
        return prog[{elem, 3'b000} +: BYTE_W];
    endfunction

endpackage

[rtl/core/mtsg_cfg.sv]
// Configuration registers of the march test sequence generator, with range clamping.
module mtsg_cfg
    import mtsg_pkg::*;
#(
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [PROG_W-1:0]      wr_data,
    output cfg_t                   cfg
);

    localparam logic [LOG2_W-1:0]  ADDR_BITS_L = LOG2_W'(ADDR_BITS);
    localparam logic [COUNT_W-1:0] MAX_ELEM_L  = COUNT_W'(MAX_ELEMENTS);

    logic [LOG2_W-1:0]  log2_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PROG_W-1:0]  program_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg    <= RST_MEM_SIZE_LOG2;
            count_reg   <= RST_ELEMENT_COUNT;
            program_reg <= RST_MARCH_PROGRAM;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_MEM_SIZE_LOG2: log2_reg    <= wr_data[LOG2_W-1:0];
                CFG_ELEMENT_COUNT: count_reg   <= wr_data[COUNT_W-1:0];
                CFG_MARCH_PROGRAM: program_reg <= wr_data;
                default:           ;
            endcase
        end
    end

    // Zero counts as one; clamp the top end to the build limits
    always_comb
    begin
        if (log2_reg == '0)
            cfg.size_log2 = LOG2_W'(1);
        else if (log2_reg > ADDR_BITS_L)
            cfg.size_log2 = ADDR_BITS_L;
        else
            cfg.size_log2 = log2_reg;

        if (count_reg == '0)
            cfg.elem_count = COUNT_W'(1);
        else if (count_reg > MAX_ELEM_L)
            cfg.elem_count = MAX_ELEM_L;
        else
            cfg.elem_count = count_reg;

        cfg.prog = program_reg;
    end

endmodule

[rtl/core/mtsg_seq.sv]
// March sequencer: position state and the single-pass step logic.
module mtsg_seq
    import mtsg_pkg::*;
#(
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int MAX_OPS      = DEF_MAX_OPS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step,
    input  logic    restart,
    output result_t res
);

    localparam logic [OPS_W-1:0] MAX_OPS_L = OPS_W'(MAX_OPS);

    logic [ELEM_W-1:0]    element_pos_reg, element_pos_next;
    logic [ADDR_BITS-1:0] address_pos_reg, address_pos_next;
    logic [OP_W-1:0]      op_pos_reg, op_pos_next;
    logic                 finished_reg, finished_next;

    logic [ADDR_BITS-1:0] addr_mask;
    logic [BYTE_W-1:0]    first_byte, cur_byte, next_byte;
    logic [ELEM_W-1:0]    cur_elem, next_elem;
    logic [OP_W-1:0]      cur_op;
    logic [ADDR_BITS-1:0] cur_addr_raw, cur_addr;
    logic                 cur_fin;
    logic [OPS_W-1:0]     ops_raw, ops;
    logic                 desc, end_addr, end_elem, last_elem, last;

    always_comb
    begin
        for (int i = 0; i < ADDR_BITS; i++)
            addr_mask[i] = (LOG2_W'(i) < cfg.size_log2);
    end

    always_comb
    begin
        // Restart takes effect before the step
        first_byte   = elem_byte(cfg.prog, '0);
        cur_elem     = restart ? '0 : element_pos_reg;
        cur_op       = restart ? '0 : op_pos_reg;
        cur_addr_raw = restart ? (first_byte[0] ? addr_mask : '0) : address_pos_reg;
        cur_fin      = restart ? 1'b0 : finished_reg;

        cur_byte  = elem_byte(cfg.prog, cur_elem);
        desc      = cur_byte[0];
        ops_raw   = {1'b0, cur_byte[2:1]} + OPS_W'(1);
        ops       = (ops_raw > MAX_OPS_L) ? MAX_OPS_L : ops_raw;
        cur_addr  = cur_addr_raw & addr_mask;

        end_addr  = (({1'b0, cur_op}) + OPS_W'(1)) >= ops;
        end_elem  = end_addr && (desc ? (cur_addr == '0) : (cur_addr == addr_mask));
        last_elem = (({1'b0, cur_elem}) + COUNT_W'(1)) >= cfg.elem_count;
        last      = end_elem && last_elem;

        next_elem = cur_elem + ELEM_W'(1);
        next_byte = elem_byte(cfg.prog, next_elem);

        res.valid         = !cur_fin;
        res.address       = ADDR_W'(cur_addr);
        res.is_write      = cur_byte[3'd3 + {1'b0, cur_op}];
        res.element_index = cur_elem;
        res.last          = last;

        element_pos_next = cur_elem;
        op_pos_next      = cur_op;
        address_pos_next = cur_addr_raw;
        finished_next    = cur_fin;
        if (!cur_fin)
        begin
            if (last)
            begin
                finished_next = 1'b1;
            end
            else if (end_elem)
            begin
                element_pos_next = next_elem;
                op_pos_next      = '0;
                address_pos_next = next_byte[0] ? addr_mask : '0;
            end
            else if (end_addr)
            begin
                op_pos_next      = '0;
                address_pos_next = desc ? (cur_addr - ADDR_BITS'(1))
                                        : (cur_addr + ADDR_BITS'(1));
            end
            else
            begin
                op_pos_next      = cur_op + OP_W'(1);
                address_pos_next = cur_addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_pos_reg <= '0;
            address_pos_reg <= '0;
            op_pos_reg      <= '0;
            finished_reg    <= 1'b0;
        end
        else if (step)
        begin
            element_pos_reg <= element_pos_next;
            address_pos_reg <= address_pos_next;
            op_pos_reg      <= op_pos_next;
            finished_reg    <= finished_next;
        end
    end

    a_op_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, op_pos_reg} < MAX_OPS_L))
        else $error("operation position beyond operation limit");

    a_elem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, element_pos_reg} < COUNT_W'(MAX_ELEMENTS)))
        else $error("element position beyond element limit");

    a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.valid && res.last) |=> finished_reg)
        else $error("last operation did not mark the run finished");

endmodule

[rtl/core/march_test_sequence_generator.sv]
// Top level of the march test sequence generator: ports, result register and handshake.
//
// Usage
// - Each input transfer on s_* is one tick. s_tdata[0] is restart: 1 starts the
//   program over at element 0 and issues its first operation on the same tick.
// - Each tick that is not past the end of the program yields one result on m_*:
//   the memory address, read/write and element index, with m_tlast on the final
//   operation. Ticks after the final operation yield nothing until a restart.
// - Result: registered, so it appears on m_* in the cycle after its input transfer.
// - Throughput: one tick per cycle unless a held result stalls; the whole step is
//   one pass of logic between the position registers and the result register.
// - Stall: while m_tready is low a held result stays put and s_tready drops;
//   s_tready is high whenever the result register is empty or being drained,
//   so the input side loses no cycle under a ready receiver.
// - Configuration: cfg_valid/cfg_index/cfg_data, always ready. Index 0 is the
//   memory size as log2, 1 the element count, 2 the packed march program
//   (one byte per element: bit0 descending, bits2:1 op count minus one,
//   bits6:3 op kinds, 1 = write). Write only while the block is idle.
// - Reset: asynchronous, active low. Registers return to 2^20 addresses, one
//   element, an all-zero program, and the position to element 0, address 0.
module march_test_sequence_generator
    import mtsg_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int MAX_OPS      = DEF_MAX_OPS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Tick stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero

    // Operation stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [29:0] address, [30] is_write,
                                              // [33:31] element_index, [39:34] zero
    output logic                   m_tlast,

    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PROG_W-1:0]      cfg_data
);

    cfg_t    cfg;
    result_t res;
    logic    step;

    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_write_reg;
    logic [ELEM_W-1:0] out_elem_reg;
    logic              out_last_reg;

    // Configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    mtsg_cfg #(
        .ADDR_BITS    (ADDR_BITS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Accept a tick whenever the result register is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    mtsg_seq #(
        .ADDR_BITS    (ADDR_BITS),
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_OPS      (MAX_OPS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (step),
        .restart (s_tdata[0]),
        .res     (res)
    );

    // Hold the result until the receiver takes it; load a fresh one on each tick that yields one
    always_comb
    begin
        if (step)
            out_valid_next = res.valid;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_addr_reg  <= res.address;
            out_write_reg <= res.is_write;
            out_elem_reg  <= res.element_index;
            out_last_reg  <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_elem_reg, out_write_reg, out_addr_reg});
    assign m_tlast  = out_last_reg;

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.valid) |=> m_tvalid)
        else $error("result of an accepted tick not presented");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !step) |=> !m_tvalid)
        else $error("result repeated after its transfer");

    a_no_result_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !res.valid) |=> !m_tvalid)
        else $error("result invented for a tick past the end");

endmodule

[dv/tb.sv]
// Self-checking testbench for the march test sequence generator.
module tb;
    import mtsg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Tuning of the run
    localparam int TICK_TARGET = 1400;  // operations to produce before stopping
    localparam int CALM_FROM   = 1200;  // no random idling on either side from here on
    localparam int SQUEEZE_AT  = 300;   // long receiver hold-off starts here
    localparam int SQUEEZE_LEN = 60;
    localparam int SETTLE      = 3;     // pause for a tick that produced nothing
    localparam int STALL_LIMIT = 1000;  // cycles without any transfer

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(3);  // no register here

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              wr;
        logic [ELEM_W-1:0] elem;
        logic              last;
    } op_rec_t;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [PROG_W-1:0]       data;
        logic                    restart;
        logic                    typed;   // expected operation typed in below
        op_rec_t                 want;
    } plan_row_t;

    localparam int PLAN_ROWS = 25;

    // Directed opening: reset state, extreme sizes and counts, a program of all
    // ones, shrinking the memory and the program under a run in progress, the
    // unused register index, the final operation and ticks past the end.
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'd0, OP_READ, 3'd0, 1'b0}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'd1, OP_READ, 3'd0, 1'b0}},
        '{ROW_CFG, CFG_MEM_SIZE_LOG2, 64'd31, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_MARCH_PROGRAM, {PROG_W{1'b1}}, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_ELEMENT_COUNT, 64'd15, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{30'h3FFF_FFFF, OP_WRITE, 3'd0, 1'b0}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'h3FFF_FFFF, OP_WRITE, 3'd0, 1'b0}},
        '{ROW_CFG, CFG_MEM_SIZE_LOG2, 64'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_MARCH_PROGRAM, 64'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_ELEMENT_COUNT, 64'd0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_SPARE, {PROG_W{1'b1}}, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_MEM_SIZE_LOG2, 64'd1, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{30'd0, OP_READ, 3'd0, 1'b0}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'd1, OP_READ, 3'd0, 1'b1}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_MARCH_PROGRAM, 64'h35, 1'b0, 1'b0, '0},
        '{ROW_TICK, '0, '0, 1'b1, 1'b1, '{30'd1, OP_READ, 3'd0, 1'b0}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'd1, OP_WRITE, 3'd0, 1'b0}},
        '{ROW_TICK, '0, '0, 1'b0, 1'b1, '{30'd1, OP_WRITE, 3'd0, 1'b0}}
    };

    // Every input known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [0] restart, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [29:0] address, [30] is_write,
                                              // [33:31] element_index, [39:34] zero
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [PROG_W-1:0]      cfg_data  = '0;

    march_test_sequence_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Generator copy: configuration as written, and the walk position
    logic [LOG2_W-1:0]  size_log2 = RST_MEM_SIZE_LOG2;
    logic [COUNT_W-1:0] elem_total = RST_ELEMENT_COUNT;
    logic [PROG_W-1:0]  program_word = RST_MARCH_PROGRAM;
    logic [ELEM_W-1:0]  elem_at = '0;
    logic [ADDR_W-1:0]  addr_at = '0;   // the reset program ascends, so address 0
    logic [OP_W-1:0]    op_at = '0;
    logic               run_done = 1'b0;

    op_rec_t ops_due[$];       // operations still owed by the block, oldest first

    int  fails = 0;
    int  ticks_sent = 0;
    int  ops_made = 0;
    int  ends_seen = 0;
    int  reg_writes = 0;
    bit  calm = 1'b0;
    bit  squeeze = 1'b0;

    // Address count, with the size clamped to 1..ADDR_W
    function automatic logic [ADDR_W:0] addr_span();
        int n;
        n = size_log2;
        if (n < 1) n = 1;
        if (n > DEF_ADDR_BITS) n = DEF_ADDR_BITS;
        return (ADDR_W+1)'(1) << n;
    endfunction

    function automatic logic [BYTE_W-1:0] descriptor(input logic [ELEM_W-1:0] e);
        return program_word[{e, 3'b000} +: BYTE_W];
    endfunction

    // First address of an element: top of memory when it descends
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ELEM_W-1:0] e);
        logic [ADDR_W:0] top;
        top = addr_span() - 1'b1;
        return descriptor(e)[0] ? top[ADDR_W-1:0] : '0;
    endfunction

    // Advance the walk by one tick; returns 1 with the operation when one is issued
    function automatic logic march_step(input logic restart, output op_rec_t op);
        logic [ADDR_W:0]   span;
        logic [BYTE_W-1:0] desc_byte;
        logic [ADDR_W-1:0] a;
        int                nops;
        int                count;
        logic              end_addr;
        logic              end_elem;
        op = '0;
        if (restart)
        begin
            elem_at  = '0;
            op_at    = '0;
            run_done = 1'b0;
            addr_at  = entry_addr('0);
        end
        if (run_done) return 1'b0;

        span      = addr_span();
        desc_byte = descriptor(elem_at);
        nops      = desc_byte[2:1] + 1;
        a         = ADDR_W'(addr_at & (span - 1'b1));
        count     = elem_total;
        if (count < 1) count = 1;
        if (count > DEF_MAX_ELEMENTS) count = DEF_MAX_ELEMENTS;

        end_addr = (op_at + 1 >= nops);
        end_elem = end_addr && (desc_byte[0] ? (a == '0) : ({1'b0, a} == span - 1'b1));

        op.addr = a;
        op.wr   = desc_byte[3 + op_at];
        op.elem = elem_at;
        op.last = end_elem && (elem_at + 1 >= count);

        if (op.last)
            run_done = 1'b1;
        else if (end_elem)
        begin
            elem_at = elem_at + 1'b1;
            op_at   = '0;
            addr_at = entry_addr(elem_at);
        end
        else if (end_addr)
        begin
            op_at   = '0;
            addr_at = desc_byte[0] ? a - 1'b1 : a + 1'b1;
        end
        else
        begin
            op_at   = op_at + 1'b1;
            addr_at = a;
        end
        return 1'b1;
    endfunction

    // Offer one tick, hold it until transferred, then note what it should produce
    task automatic drive_tick(input logic restart, input logic typed, input op_rec_t want);
        op_rec_t op;
        logic    issued;
        s_tdata  <= IN_TDATA_W'(restart);
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        issued = march_step(restart, op);
        ticks_sent++;
        if (issued)
        begin
            ops_made++;
            ops_due.push_back(typed ? want : op);
        end
    endtask

    // Drop valid and leave the input side quiet for the given number of cycles
    task automatic rest_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PROG_W-1:0] val);
        s_tvalid <= 1'b0;
        while (ops_due.size() != 0) @(posedge clk);
        // a finished walk can leave the last tick without any operation in flight
        repeat (SETTLE) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_MEM_SIZE_LOG2: size_log2    = val[LOG2_W-1:0];
            CFG_ELEMENT_COUNT: elem_total   = val[COUNT_W-1:0];
            CFG_MARCH_PROGRAM: program_word = val;
            default: ;
        endcase
    endtask

    function automatic void flag_field(input string field, input longint unsigned want,
                                       input longint unsigned seen);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
        fails++;
    endfunction

    // Check each operation transfer against the oldest one owed
    always @(posedge clk)
    begin : check_ops
        op_rec_t seen;
        op_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = '{m_tdata[ADDR_W-1:0], m_tdata[ADDR_W], m_tdata[ADDR_W+1 +: ELEM_W], m_tlast};
            if (seen.last) ends_seen++;
            if (ops_due.size() == 0)
            begin
                $display("%0t ns: unexpected operation, expected none, got 0x%0h",
                         $time, seen);
                fails++;
            end
            else
            begin
                want = ops_due.pop_front();
                if (seen.addr !== want.addr) flag_field("address", want.addr, seen.addr);
                if (seen.wr !== want.wr) flag_field("is_write", want.wr, seen.wr);
                if (seen.elem !== want.elem) flag_field("element_index", want.elem, seen.elem);
                if (seen.last !== want.last) flag_field("last", want.last, seen.last);
            end
        end
    end

    // Receiver: random ready bursts, one long hold-off on request, steady at the end
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze)
            begin
                m_tready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge clk);
                squeeze = 1'b0;
            end
            else if (calm || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Watchdog: give up when nothing has been transferred for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL march_test_sequence_generator");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        bit       fresh;
        bit       wide;
        bit       noisy;
        bit       squeezed;
        int       budget;
        int       tail;
        logic [PROG_W-1:0] val;
        squeezed = 1'b0;

        // hold reset, then release it on an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (PLAN[r].kind == ROW_CFG)
                write_reg(PLAN[r].idx, PLAN[r].data);
            else
                drive_tick(PLAN[r].restart, PLAN[r].typed, PLAN[r].want);
        end

        // random phases: reprogram, then walk the program with noise to its end or the tick budget
        while (ops_made < TICK_TARGET)
        begin
            wide  = ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 3) != 0);
            if (wide || $urandom_range(0, 3) != 0)
            begin
                val = {$urandom, $urandom};
                val[LOG2_W-1:0] = wide ? LOG2_W'($urandom_range(4, 31))
                                       : LOG2_W'($urandom_range(0, 3));
                write_reg(CFG_MEM_SIZE_LOG2, val);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                val = {$urandom, $urandom};
                val[COUNT_W-1:0] = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 15))
                                                               : COUNT_W'($urandom_range(1, 8));
                write_reg(CFG_ELEMENT_COUNT, val);
            end
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_MARCH_PROGRAM, {$urandom, $urandom});

            // mostly start from the top; otherwise carry on from where the walk stood
            fresh  = ($urandom_range(0, 4) != 0);
            budget = wide ? $urandom_range(20, 50) : 400;
            tail   = $urandom_range(1, 3);
            for (int k = 0; k < budget && tail > 0; k++)
            begin
                drive_tick((k == 0 && fresh) || $urandom_range(0, 59) == 0, 1'b0, '0);
                if (run_done) tail--;
                if (!squeezed && ops_made >= SQUEEZE_AT)
                begin
                    squeezed = 1'b1;
                    squeeze  = 1'b1;
                end
                if (ops_made >= CALM_FROM) calm = 1'b1;
                if (!calm && noisy && $urandom_range(0, 4) == 0)
                    rest_sender($urandom_range(1, 6));
            end
        end

        // drain, then allow the result register to settle
        s_tvalid <= 1'b0;
        while (ops_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d ticks and %0d checked operations over %0d register writes,",
                 ticks_sent, ops_made, reg_writes);
        $display("reaching the end of a program %0d times, with %0d mismatches.",
                 ends_seen, fails);
        if (fails == 0)
            $display("PASS march_test_sequence_generator");
        else
            $display("FAIL march_test_sequence_generator");
        $finish;
    end

endmodule

[march_test_sequence_generator.f]
rtl/core/mtsg_pkg.sv
rtl/core/mtsg_cfg.sv
rtl/core/mtsg_seq.sv
rtl/core/march_test_sequence_generator.sv
dv/tb.sv
